[rtl/srpa_pkg.sv]
// Shared types and constants of the sparse row pattern assembler.
// Depends on nothing; the top level and the testbench refer to it by scoped names.
package srpa_pkg;

   localparam int MAX_ROWS        = 1024;
   localparam int MAX_ENTRIES     = 8192;
   localparam int MAX_BLOCK_ELEMS = 4;

   localparam int ROW_AW  = $clog2(MAX_ROWS);
   localparam int SLOT_AW = $clog2(MAX_ENTRIES);
   localparam int ELEM_AW = $clog2(MAX_BLOCK_ELEMS);
   localparam int VAL_AW  = SLOT_AW + ELEM_AW;
   localparam int SLOT_W  = 14;

   // Opcodes of a request beat.
   localparam logic [2:0] OP_SET_LEN = 3'd0;
   localparam logic [2:0] OP_FIND    = 3'd1;
   localparam logic [2:0] OP_INSERT  = 3'd2;
   localparam logic [2:0] OP_WRITE   = 3'd3;
   localparam logic [2:0] OP_ADD     = 3'd4;

   // Status codes of a response beat.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_RANGE      = 3'd1;
   localparam logic [2:0] ST_ROW_UNSET  = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;
   localparam logic [2:0] ST_PREV_UNSET = 3'd5;
   localparam logic [2:0] ST_OVERFLOW   = 3'd6;

   // Configuration register indexes.
   localparam logic [1:0] CSR_NUM_ROWS    = 2'd0;
   localparam logic [1:0] CSR_BLOCK_ELEMS = 2'd1;
   localparam logic [1:0] CSR_CAPACITY    = 2'd2;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [9:0]         row;
      logic [9:0]         col;
      logic [10:0]        length;
      logic [1:0]         elem;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [12:0]        entry_index;
      logic signed [31:0] element_value;
      logic [13:0]        total_nonzeros;
   } rsp_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_ROW   = 8'b0000_0010,
      S_SET2  = 8'b0000_0100,
      S_DIAG  = 8'b0000_1000,
      S_SCAN  = 8'b0001_0000,
      S_VAL   = 8'b0010_0000,
      S_VWAIT = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

endpackage

[rtl/srpa_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module srpa_ram #(
   parameter int WIDTH = 32,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [2**AW];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/sparse_row_pattern_assembler_top.sv]
// Top level of the sparse row pattern assembler: sequencer, configuration
// registers and the three state memories. Uses srpa_pkg and srpa_ram.
//
// Usage: request beats (req_valid, req_stall, req_data) carry one operation
// each: set row length, find, insert entry, write value or add value. Every
// request gives exactly one response beat (rsp_valid, rsp_stall, rsp_data)
// with status, slot, element value and the running nonzero count.
// Configuration registers are written through csr_we, csr_index, csr_wdata
// while the block is idle.
// Order of work: a range error goes straight to the response. Set row length
// writes the row start, its length and then the following row's start unless
// it is the last row. Other operations read the row start and the diagonal
// slot, then scan the column slots unless the column is the diagonal; find,
// write and add then read the value memory. One item is worked on at a time;
// the row scan through the column slot memory sets the rate.
// Reset: reset is synchronous. After it the block sweeps all three
// memories, one address a cycle, and holds req_stall high.
// A finished response waits in an output register while rsp_stall is high;
// the next request is still taken, and its response waits behind it.
module sparse_row_pattern_assembler_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srpa_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [13:0]      csr_wdata
);

   localparam int RAW = srpa_pkg::ROW_AW;
   localparam int SAW = srpa_pkg::SLOT_AW;
   localparam int VAW = srpa_pkg::VAL_AW;
   localparam int SW  = srpa_pkg::SLOT_W;

   // Configuration registers.
   logic [10:0] num_rows_ff;
   logic [2:0]  block_elems_ff;
   logic [13:0] capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff    <= 11'd1024;
         block_elems_ff <= 3'd1;
         capacity_ff    <= 14'd8192;
      end else if (csr_we) begin
         unique case (csr_index)
            srpa_pkg::CSR_NUM_ROWS:    num_rows_ff    <= csr_wdata[10:0];
            srpa_pkg::CSR_BLOCK_ELEMS: block_elems_ff <= csr_wdata[2:0];
            srpa_pkg::CSR_CAPACITY:    capacity_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Values in use, clamped to their legal ranges.
   logic [10:0] n_use;
   logic [2:0]  bb_use;
   logic [13:0] cap_use;

   always_comb begin
      n_use = num_rows_ff;
      if (num_rows_ff == '0) n_use = 11'd1;
      else if (num_rows_ff > 11'(srpa_pkg::MAX_ROWS)) n_use = 11'(srpa_pkg::MAX_ROWS);
      bb_use = block_elems_ff;
      if (block_elems_ff == '0) bb_use = 3'd1;
      else if (block_elems_ff > 3'(srpa_pkg::MAX_BLOCK_ELEMS))
         bb_use = 3'(srpa_pkg::MAX_BLOCK_ELEMS);
      cap_use = capacity_ff;
      if (capacity_ff == '0) cap_use = 14'd1;
      else if (capacity_ff > 14'(srpa_pkg::MAX_ENTRIES))
         cap_use = 14'(srpa_pkg::MAX_ENTRIES);
   end

   // Memory ports.
   logic           rs_we;
   logic [RAW-1:0] rs_waddr, rs_raddr;
   logic [SW-1:0]  rs_wdata, rs_rdata;
   logic           cs_we;
   logic [SAW-1:0] cs_waddr, cs_raddr;
   logic [SW-1:0]  cs_wdata, cs_rdata;
   logic           bv_we;
   logic [VAW-1:0] bv_waddr, bv_raddr;
   logic [31:0]    bv_wdata, bv_rdata;

   srpa_ram #(.WIDTH(SW), .AW(RAW)) u_row_start (
      .clock(clock), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
      .raddr(rs_raddr), .rdata(rs_rdata));

   srpa_ram #(.WIDTH(SW), .AW(SAW)) u_column_slot (
      .clock(clock), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
      .raddr(cs_raddr), .rdata(cs_rdata));

   srpa_ram #(.WIDTH(32), .AW(VAW)) u_block_values (
      .clock(clock), .we(bv_we), .waddr(bv_waddr), .wdata(bv_wdata),
      .raddr(bv_raddr), .rdata(bv_rdata));

   // Sequencer registers.
   srpa_pkg::state_type state_ff, state_in;
   srpa_pkg::req_type   item_ff, item_in;
   logic [2:0]     status_ff, status_in;
   logic [12:0]    slot_ff, slot_in;
   logic [31:0]    ev_ff, ev_in;
   logic [SW-1:0]  start_ff, start_in;
   logic [SW:0]    lim_ff, lim_in;
   logic [SW-1:0]  k_ff, k_in;
   logic [SW-1:0]  end_ff, end_in;
   logic [13:0]    count_ff, count_in;
   logic           clr_ff;
   logic [VAW-1:0] clr_cnt_ff;
   logic           rsp_valid_ff;
   srpa_pkg::rsp_type rsp_ff;

   logic req_accept;
   logic out_free;
   assign req_stall  = clr_ff || (state_ff != srpa_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Scratch values of the combinational sequencer.
   logic [2:0]    range_st;
   logic          unset_rs;
   logic [SW-1:0] s_new;
   logic [SW:0]   end_sum;
   logic          last_row;
   logic [14:0]   cnt_sum;
   logic [SW-1:0] k_next;
   logic          claim;
   logic [32:0]   add_sum;
   logic [31:0]   add_sat;

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      ev_in     = ev_ff;
      start_in  = start_ff;
      lim_in    = lim_ff;
      k_in      = k_ff;
      end_in    = end_ff;
      count_in  = count_ff;

      rs_we = 1'b0; rs_waddr = item_ff.row; rs_wdata = start_ff;
      rs_raddr = item_ff.row;
      cs_we = 1'b0; cs_waddr = k_ff[SAW-1:0]; cs_wdata = SW'(item_ff.col);
      cs_raddr = k_ff[SAW-1:0];
      bv_we = 1'b0; bv_waddr = {slot_ff, item_ff.elem};
      bv_wdata = item_ff.value; bv_raddr = {slot_ff, item_ff.elem};

      // Range check of an incoming request.
      range_st = srpa_pkg::ST_OK;
      if (req_data.opcode > srpa_pkg::OP_ADD || 11'(req_data.row) >= n_use)
         range_st = srpa_pkg::ST_RANGE;
      else if (req_data.opcode == srpa_pkg::OP_SET_LEN) begin
         if (req_data.length == '0) range_st = srpa_pkg::ST_RANGE;
      end else if (11'(req_data.col) >= n_use ||
                   (req_data.opcode != srpa_pkg::OP_INSERT &&
                    3'(req_data.elem) >= bb_use))
         range_st = srpa_pkg::ST_RANGE;

      unset_rs = rs_rdata[SW-1];
      s_new    = (item_ff.row == '0) ? '0 : rs_rdata;
      end_sum  = (SW+1)'(s_new) + (SW+1)'(item_ff.length);
      last_row = !((11'(item_ff.row) + 11'd1) < n_use);
      cnt_sum  = 15'(count_ff) + 15'(item_ff.length);
      k_next   = k_ff + 1'b1;
      claim    = item_ff.opcode != srpa_pkg::OP_FIND;
      add_sum  = {item_ff.value[31], item_ff.value} + {bv_rdata[31], bv_rdata};
      add_sat  = add_sum[31:0];
      if (add_sum[32] != add_sum[31]) add_sat = add_sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;

      unique case (state_ff)
         srpa_pkg::S_IDLE: begin
            rs_raddr = req_data.row;
            if (req_accept) begin
               item_in   = req_data;
               status_in = range_st;
               slot_in   = '0;
               ev_in     = '0;
               state_in  = (range_st == srpa_pkg::ST_OK) ? srpa_pkg::S_ROW
                                                         : srpa_pkg::S_DONE;
            end
         end
         // Row start is back from memory.
         srpa_pkg::S_ROW: begin
            if (item_ff.opcode == srpa_pkg::OP_SET_LEN) begin
               if (item_ff.row != '0 && unset_rs) begin
                  status_in = srpa_pkg::ST_PREV_UNSET;
                  state_in  = srpa_pkg::S_DONE;
               end else if (last_row ? (end_sum > (SW+1)'(cap_use))
                                     : (end_sum >= (SW+1)'(cap_use))) begin
                  status_in = srpa_pkg::ST_OVERFLOW;
                  state_in  = srpa_pkg::S_DONE;
               end else begin
                  rs_we    = 1'b1;
                  rs_wdata = s_new;
                  cs_we    = 1'b1;
                  cs_waddr = s_new[SAW-1:0];
                  cs_wdata = SW'(item_ff.length);
                  count_in = (cnt_sum > 15'(srpa_pkg::MAX_ENTRIES))
                             ? 14'(srpa_pkg::MAX_ENTRIES) : cnt_sum[13:0];
                  slot_in  = s_new[12:0];
                  end_in   = end_sum[SW-1:0];
                  state_in = last_row ? srpa_pkg::S_DONE : srpa_pkg::S_SET2;
               end
            end else if (unset_rs) begin
               status_in = srpa_pkg::ST_ROW_UNSET;
               state_in  = srpa_pkg::S_DONE;
            end else begin
               start_in = rs_rdata;
               cs_raddr = rs_rdata[SAW-1:0];
               state_in = srpa_pkg::S_DIAG;
            end
         end
         // Start of the following row.
         srpa_pkg::S_SET2: begin
            rs_we    = 1'b1;
            rs_waddr = item_ff.row + 1'b1;
            rs_wdata = end_ff;
            state_in = srpa_pkg::S_DONE;
         end
         // Diagonal slot holds the row length.
         srpa_pkg::S_DIAG: begin
            lim_in = (SW+1)'(start_ff) + (SW+1)'(cs_rdata);
            k_in   = start_ff + 1'b1;
            cs_raddr = k_in[SAW-1:0];
            if (cs_rdata == '1) begin
               status_in = srpa_pkg::ST_ROW_UNSET;
               state_in  = srpa_pkg::S_DONE;
            end else if (item_ff.row == item_ff.col) begin
               slot_in  = start_ff[12:0];
               state_in = srpa_pkg::S_VAL;
            end else if ((SW+1)'(k_in) < lim_in &&
                         k_in < SW'(srpa_pkg::MAX_ENTRIES)) begin
               state_in = srpa_pkg::S_SCAN;
            end else begin
               status_in = claim ? srpa_pkg::ST_FULL : srpa_pkg::ST_NOT_FOUND;
               state_in  = srpa_pkg::S_DONE;
            end
         end
         // One column slot checked a cycle.
         srpa_pkg::S_SCAN: begin
            cs_raddr = k_next[SAW-1:0];
            if (cs_rdata == SW'(item_ff.col)) begin
               slot_in  = k_ff[12:0];
               state_in = srpa_pkg::S_VAL;
            end else if (claim && cs_rdata == '1) begin
               cs_we    = 1'b1;
               slot_in  = k_ff[12:0];
               state_in = srpa_pkg::S_VAL;
            end else if ((SW+1)'(k_next) < lim_ff &&
                         k_next < SW'(srpa_pkg::MAX_ENTRIES)) begin
               k_in = k_next;
            end else begin
               status_in = claim ? srpa_pkg::ST_FULL : srpa_pkg::ST_NOT_FOUND;
               state_in  = srpa_pkg::S_DONE;
            end
         end
         // Value memory read is issued here.
         srpa_pkg::S_VAL: begin
            state_in = (item_ff.opcode == srpa_pkg::OP_INSERT) ? srpa_pkg::S_DONE
                                                                : srpa_pkg::S_VWAIT;
         end
         // Element access: find reads it, write replaces it, add writes back the saturated sum.
         srpa_pkg::S_VWAIT: begin
            case (item_ff.opcode)
               srpa_pkg::OP_WRITE: begin
                  bv_we = 1'b1;
                  ev_in = item_ff.value;
               end
               srpa_pkg::OP_ADD: begin
                  bv_we    = 1'b1;
                  bv_wdata = add_sat;
                  ev_in    = add_sat;
               end
               default: ev_in = bv_rdata;
            endcase
            state_in = srpa_pkg::S_DONE;
         end
         srpa_pkg::S_DONE: begin
            if (out_free) state_in = srpa_pkg::S_IDLE;
         end
         default: state_in = srpa_pkg::S_IDLE;
      endcase

      // The clearing sweep owns every write port.
      if (clr_ff) begin
         rs_we = 1'b1; rs_waddr = clr_cnt_ff[RAW-1:0]; rs_wdata = '1;
         cs_we = 1'b1; cs_waddr = clr_cnt_ff[SAW-1:0]; cs_wdata = '1;
         bv_we = 1'b1; bv_waddr = clr_cnt_ff; bv_wdata = '0;
      end
   end

   // Sequencer state and clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= srpa_pkg::S_IDLE;
         count_ff   <= '0;
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) clr_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      ev_ff     <= ev_in;
      start_ff  <= start_in;
      lim_ff    <= lim_in;
      k_ff      <= k_in;
      end_ff    <= end_in;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == srpa_pkg::S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == srpa_pkg::S_DONE && out_free) begin
         rsp_ff.status         <= status_ff;
         rsp_ff.entry_index    <= (status_ff == srpa_pkg::ST_OK) ? slot_ff : '0;
         rsp_ff.element_value  <= (status_ff == srpa_pkg::ST_OK) ? ev_ff : '0;
         rsp_ff.total_nonzeros <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks on the sequencer.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_accept) else $error("request taken during clearing sweep");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != srpa_pkg::S_IDLE)
      else $error("sequencer stayed idle after a request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 14'(srpa_pkg::MAX_ENTRIES)) else $error("nonzero count past limit");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == srpa_pkg::S_DONE))
      else $error("response without a finished item");

endmodule

[dv/tb.sv]
// Self-checking testbench for the sparse row pattern assembler.
// Drives request beats through a directed table and random phases; typed rows carry
// their response, others come from a behavioral store model. Depends on srpa_pkg.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 6000000;
   localparam int ERR_SHOWN   = 10;
   localparam logic [31:0] UNSET = 32'hFFFF_FFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   srpa_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   srpa_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [1:0]  csr_index = srpa_pkg::CSR_NUM_ROWS;
   logic [13:0] csr_wdata = '0;

   sparse_row_pattern_assembler_top dut (.*);

   always #5 clock = ~clock;

   // Shadow copy of the configuration and of the three stores.
   logic [10:0] cfg_rows  = 11'd1024;
   logic [2:0]  cfg_elems = 3'd1;
   logic [13:0] cfg_cap   = 14'd8192;
   logic [31:0] row_first [srpa_pkg::MAX_ROWS];
   logic [31:0] slot_col  [srpa_pkg::MAX_ENTRIES];
   logic signed [31:0] elem_vals [srpa_pkg::MAX_ENTRIES*srpa_pkg::MAX_BLOCK_ELEMS];
   logic [31:0] nz_total = 0;

   srpa_pkg::rsp_type expected_rsp [$];
   int      mismatches = 0;
   int      cycles = 0;
   int      send_idle = 0;
   int      recv_stall = 0;

   typedef struct {
      srpa_pkg::req_type q;
      bit      typed;
      srpa_pkg::rsp_type want;
   } dir_row_type;

   initial begin
      foreach (row_first[i]) row_first[i] = UNSET;
      foreach (slot_col[i])  slot_col[i]  = UNSET;
      foreach (elem_vals[i]) elem_vals[i] = 0;
   end

   function automatic logic [31:0] clamp_to(logic [31:0] v, logic [31:0] hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Applies one operation to the shadow stores and returns its response.
   function automatic srpa_pkg::rsp_type assemble_step(srpa_pkg::req_type q);
      logic [31:0] n, bb, cap, s, len, slot, stop, k, a;
      logic [2:0]  st;
      logic signed [31:0] ev;
      logic signed [63:0] sum;
      bit      done;
      srpa_pkg::rsp_type r;
      n = clamp_to(cfg_rows, srpa_pkg::MAX_ROWS);
      bb = clamp_to(cfg_elems, srpa_pkg::MAX_BLOCK_ELEMS);
      cap = clamp_to(cfg_cap, srpa_pkg::MAX_ENTRIES);
      st = srpa_pkg::ST_OK;
      slot = 0;
      ev = 0;
      if (q.opcode > srpa_pkg::OP_ADD || q.row >= n) begin
         st = srpa_pkg::ST_RANGE;
      end else if (q.opcode == srpa_pkg::OP_SET_LEN) begin
         // Row length: start is 0 for the first row, else set by the row above.
         s = (q.row == 0) ? 0 : row_first[q.row];
         stop = s + q.length;
         if (q.length == 0) st = srpa_pkg::ST_RANGE;
         else if (s == UNSET || s >= srpa_pkg::MAX_ENTRIES) st = srpa_pkg::ST_PREV_UNSET;
         else if (q.row + 1 < n && stop >= cap) st = srpa_pkg::ST_OVERFLOW;
         else if (q.row + 1 >= n && stop > cap) st = srpa_pkg::ST_OVERFLOW;
         else begin
            row_first[q.row] = s;
            slot_col[s] = q.length;
            nz_total = nz_total + q.length;
            if (nz_total > srpa_pkg::MAX_ENTRIES) nz_total = srpa_pkg::MAX_ENTRIES;
            if (q.row + 1 < n) row_first[q.row + 1] = stop;
            slot = s;
         end
      end else if (q.col >= n || (q.opcode != srpa_pkg::OP_INSERT && q.elem >= bb)) begin
         st = srpa_pkg::ST_RANGE;
      end else begin
         s = row_first[q.row];
         if (s == UNSET || s >= srpa_pkg::MAX_ENTRIES || slot_col[s] == UNSET) begin
            st = srpa_pkg::ST_ROW_UNSET;
         end else if (q.row == q.col) begin
            slot = s;
         end else begin
            // Scan the row's slots for the column, claiming a free one if allowed.
            len = slot_col[s];
            done = 0;
            for (k = s + 1; k < s + len && k < srpa_pkg::MAX_ENTRIES && !done; k++) begin
               if (slot_col[k] == q.col) begin
                  slot = k;
                  done = 1;
               end else if (q.opcode != srpa_pkg::OP_FIND && slot_col[k] == UNSET) begin
                  slot_col[k] = q.col;
                  slot = k;
                  done = 1;
               end
            end
            if (!done) st = (q.opcode == srpa_pkg::OP_FIND) ? srpa_pkg::ST_NOT_FOUND
                                                            : srpa_pkg::ST_FULL;
         end
         if (st == srpa_pkg::ST_OK && q.opcode != srpa_pkg::OP_INSERT) begin
            a = slot * srpa_pkg::MAX_BLOCK_ELEMS + q.elem;
            if (q.opcode == srpa_pkg::OP_WRITE) begin
               elem_vals[a] = q.value;
            end else if (q.opcode == srpa_pkg::OP_ADD) begin
               sum = 64'(elem_vals[a]) + 64'(signed'(q.value));
               if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
               if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
               elem_vals[a] = sum[31:0];
            end
            ev = elem_vals[a];
         end
      end
      if (st != srpa_pkg::ST_OK) begin
         slot = 0;
         ev = 0;
      end
      r.status = st;
      r.entry_index = slot[12:0];
      r.element_value = ev;
      r.total_nonzeros = nz_total[13:0];
      return r;
   endfunction

   function automatic srpa_pkg::req_type mk_req(logic [2:0] op, logic [9:0] row,
                                                logic [9:0] col, logic [10:0] len,
                                                logic [1:0] elem, logic [31:0] value);
      srpa_pkg::req_type q;
      q.opcode = op;
      q.row = row;
      q.col = col;
      q.length = len;
      q.elem = elem;
      q.value = value;
      return q;
   endfunction

   function automatic srpa_pkg::rsp_type mk_rsp(logic [2:0] st, logic [12:0] idx,
                                                logic [31:0] val, logic [13:0] tot);
      srpa_pkg::rsp_type r;
      r.status = st;
      r.entry_index = idx;
      r.element_value = val;
      r.total_nonzeros = tot;
      return r;
   endfunction

   // Sends one request beat, starting and ending just after a falling edge.
   task automatic send_beat(srpa_pkg::req_type q, bit typed, srpa_pkg::rsp_type want);
      srpa_pkg::rsp_type got;
      if ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         while ($urandom_range(99) < send_idle) @(negedge clock);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = q;
      do @(posedge clock); while (req_stall);
      got = assemble_step(q);
      expected_rsp.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [13:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         srpa_pkg::CSR_NUM_ROWS:    cfg_rows = data[10:0];
         srpa_pkg::CSR_BLOCK_ELEMS: cfg_elems = data[2:0];
         default:                   cfg_cap = data;
      endcase
   endtask

   // Receiver stall, changed at the falling edge.
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_stall);

   // Response checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= ERR_SHOWN)
               $display("unexpected response beat %p", rsp_data);
         end else if (rsp_data !== expected_rsp[0]) begin
            mismatches++;
            if (mismatches <= ERR_SHOWN)
               $display("mismatch: expected %p actual %p", expected_rsp[0], rsp_data);
            void'(expected_rsp.pop_front());
         end else begin
            void'(expected_rsp.pop_front());
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      dir_row_type dir [$];
      srpa_pkg::req_type q;
      int       n_used, rows_used, items, pick;
      logic [2:0] op;
      logic [31:0] val;
      logic [13:0] phase_rows [6];
      logic [13:0] phase_elems [6];
      logic [13:0] phase_cap [6];

      // Directed table: reset state, error codes, extremes and saturation.
      dir.push_back('{mk_req(srpa_pkg::OP_FIND, 0, 0, 1, 0, 0), 1,
                      mk_rsp(srpa_pkg::ST_ROW_UNSET, 0, 0, 0)});
      dir.push_back('{mk_req(srpa_pkg::OP_SET_LEN, 5, 0, 3, 0, 0), 1,
                      mk_rsp(srpa_pkg::ST_PREV_UNSET, 0, 0, 0)});
      dir.push_back('{mk_req(srpa_pkg::OP_SET_LEN, 0, 0, 0, 0, 0), 1,
                      mk_rsp(srpa_pkg::ST_RANGE, 0, 0, 0)});
      dir.push_back('{mk_req(3'd7, 0, 0, 1, 0, 0), 1, mk_rsp(srpa_pkg::ST_RANGE, 0, 0, 0)});
      dir.push_back('{mk_req(3'd5, 1023, 1023, 2047, 3, 32'hFFFF_FFFF), 1,
                      mk_rsp(srpa_pkg::ST_RANGE, 0, 0, 0)});
      dir.push_back('{mk_req(srpa_pkg::OP_SET_LEN, 0, 0, 4, 0, 0), 1,
                      mk_rsp(srpa_pkg::ST_OK, 0, 0, 4)});
      dir.push_back('{mk_req(srpa_pkg::OP_SET_LEN, 1, 0, 2047, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_INSERT, 0, 3, 0, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_INSERT, 0, 7, 0, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_INSERT, 0, 9, 0, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_INSERT, 0, 11, 0, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_WRITE, 0, 3, 0, 0, 32'h7FFF_FFFF), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_ADD, 0, 3, 0, 0, 32'd1), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_WRITE, 0, 7, 0, 0, 32'h8000_0000), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_ADD, 0, 7, 0, 0, 32'hFFFF_FFFF), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_FIND, 0, 0, 0, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_FIND, 0, 5, 0, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_FIND, 0, 3, 0, 1, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_FIND, 1, 1023, 0, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_SET_LEN, 1023, 0, 1, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_SET_LEN, 2, 0, 2047, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_SET_LEN, 3, 0, 2047, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_SET_LEN, 4, 0, 2047, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_SET_LEN, 0, 0, 4, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_INSERT, 2, 2, 0, 0, 0), 0, '0});
      dir.push_back('{mk_req(srpa_pkg::OP_ADD, 1, 1, 0, 0, 32'hFFFF_FFFB), 0, '0});

      // Settings per random phase: small, clamped and extreme values.
      phase_rows  = '{14'd16, 14'd0, 14'd2047, 14'd64, 14'd1, 14'd1024};
      phase_elems = '{14'd4, 14'd0, 14'd7, 14'd2, 14'd3, 14'd4};
      phase_cap   = '{14'd300, 14'd16383, 14'd1, 14'd8192, 14'd8192, 14'd600};

      repeat (12) @(negedge clock);
      reset = 1'b0;

      foreach (dir[i]) send_beat(dir[i].q, dir[i].typed, dir[i].want);

      for (int p = 0; p < 6; p++) begin
         drain();
         csr_write(srpa_pkg::CSR_NUM_ROWS, phase_rows[p]);
         csr_write(srpa_pkg::CSR_BLOCK_ELEMS, phase_elems[p]);
         csr_write(srpa_pkg::CSR_CAPACITY, phase_cap[p]);
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 82; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 82; end
            default: begin send_idle = 32; recv_stall = 32; end
         endcase
         n_used = clamp_to(phase_rows[p][10:0], srpa_pkg::MAX_ROWS);
         rows_used = (n_used < 24) ? n_used : 24;

         // Rows get their lengths in order so that later beats reach the scan.
         for (int r = 0; r < rows_used; r++)
            send_beat(mk_req(srpa_pkg::OP_SET_LEN, 10'(r), 0, 11'($urandom_range(8, 1)),
                             0, 0), 0, '0);

         for (items = 0; items < 260; items++) begin
            if (p == 1 && items == 130) drain();
            pick = $urandom_range(99);
            case ($urandom_range(3))
               0: val = $urandom;
               1: val = 32'h7FFF_FFFF - $urandom_range(3);
               2: val = 32'h8000_0000 + $urandom_range(3);
               default: val = $urandom_range(200) - 100;
            endcase
            if (pick < 70) begin
               op = 3'(srpa_pkg::OP_FIND + $urandom_range(3));
               q = mk_req(op, 10'($urandom_range(rows_used - 1)),
                          10'($urandom_range(rows_used - 1)),
                          11'($urandom), 2'($urandom_range(3)), val);
            end else if (pick < 80) begin
               q = mk_req(srpa_pkg::OP_SET_LEN, 10'($urandom_range(rows_used - 1)),
                          10'($urandom), 11'($urandom_range(8, 1)), 2'($urandom), 0);
            end else begin
               q = mk_req(3'($urandom_range(7)), 10'($urandom), 10'($urandom),
                          11'($urandom), 2'($urandom), $urandom);
            end
            send_beat(q, 0, '0);
         end
      end

      req_valid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
